[design/best_hamming_window_match_defines.svh]
// ---------------------------------------------------------------------------
// best hamming window match assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef BEST_HAMMING_WINDOW_MATCH_DEFINES_SVH
`define BEST_HAMMING_WINDOW_MATCH_DEFINES_SVH

// property holds at every edge
`define BHWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define BHWM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BHWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bhwm_pkg.sv]
// ---------------------------------------------------------------------------
// bhwm_pkg
// shared constants, types and helpers of the best hamming window match block
// ---------------------------------------------------------------------------
package bhwm_pkg;

  localparam int unsigned KEY_MAX  = 16;
  localparam int unsigned TEXT_MAX = 65536;

  // register file
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned KEYLEN_W  = 5;

  // derived widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KEY_IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned LEN_W     = $clog2(KEY_MAX + 1);
  localparam int unsigned SCORE_W   = 5;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned CNT_W     = $clog2(TEXT_MAX + 1);

  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN  = 2'd2
  } reg_idx_e;

  // key as seen by the datapath
  typedef struct packed {
    logic [KEY_MAX-1:0][BYTE_W-1:0] key;
    logic [LEN_W-1:0]               len;
  } key_cfg_t;

  // scored window handed from the window stage to the tracker
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [INDEX_W-1:0] start;
    logic               win_ok;
    logic               ovf;
    logic               last;
  } win_res_t;

  // key length in use: zero reads as one, large values clip at KEY_MAX
  function automatic logic [LEN_W-1:0] used_len(input logic [KEYLEN_W-1:0] raw);
    logic [31:0] wide;
    wide = 32'(raw);
    if (wide == 32'd0) begin
      used_len = LEN_W'(1);
    end else if (wide > 32'(KEY_MAX)) begin
      used_len = LEN_W'(KEY_MAX);
    end else begin
      used_len = LEN_W'(wide);
    end
  endfunction

endpackage

[design/bhwm_cfg_regs.sv]
// ---------------------------------------------------------------------------
// bhwm_cfg_regs
// apb register file holding the key bytes and the key length
// ---------------------------------------------------------------------------
module bhwm_cfg_regs import bhwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output key_cfg_t           cfg_o
);

  logic [DATA_W-1:0]   key_low_q;
  logic [DATA_W-1:0]   key_high_q;
  logic [KEYLEN_W-1:0] key_len_q;
  logic [1:0]          reg_idx;
  logic                wr_en;
  logic [2*DATA_W-1:0] key_all;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:PADDR_W-2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= KEYLEN_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_LOW:  key_low_q  <= pwdata;
        REG_KEY_HIGH: key_high_q <= pwdata;
        REG_KEY_LEN:  key_len_q  <= pwdata[KEYLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LOW:  prdata = key_low_q;
      REG_KEY_HIGH: prdata = key_high_q;
      REG_KEY_LEN:  prdata = DATA_W'(key_len_q);
      default:      prdata = '0;
    endcase
  end

  // key bytes past the two registers read as zero
  assign key_all = {key_high_q, key_low_q};

  always_comb begin
    for (int k = 0; k < KEY_MAX; k++) begin
      if (k < 2 * DATA_W / BYTE_W) begin
        cfg_o.key[k] = key_all[BYTE_W*k +: BYTE_W];
      end else begin
        cfg_o.key[k] = '0;
      end
    end
    cfg_o.len = used_len(key_len_q);
  end

endmodule

[design/bhwm_window.sv]
// ---------------------------------------------------------------------------
// bhwm_window
// text window shift line, byte count and per-window score register
// ---------------------------------------------------------------------------
module bhwm_window import bhwm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  key_cfg_t          cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] text_byte_i,
  input  logic              last_byte_i,
  input  logic              advance_i,
  output logic              res_valid_o,
  output win_res_t          res_o
);

  logic [KEY_MAX-1:0][BYTE_W-1:0] win_q, win_d, win_sh;
  logic [CNT_W-1:0]               cnt_q, cnt_d, cnt_inc;
  logic                           sat;
  logic                           accept;
  logic [KEY_MAX-1:0]             match;
  logic                           res_valid_q;
  win_res_t                       res_q, res_d;

  assign in_ready_o = advance_i;
  assign accept     = in_valid_i & advance_i;
  assign sat        = cnt_q >= CNT_W'(TEXT_MAX);
  assign cnt_inc    = cnt_q + CNT_W'(1);

  // newest byte sits at index 0
  always_comb begin
    win_sh[0] = text_byte_i;
    for (int i = 1; i < KEY_MAX; i++) begin
      win_sh[i] = win_q[i-1];
    end
  end

  // key byte k lines up with window byte len-1-k
  always_comb begin
    logic [KEY_IDX_W-1:0] sel;
    for (int k = 0; k < KEY_MAX; k++) begin
      sel      = KEY_IDX_W'(cfg_i.len - LEN_W'(1) - LEN_W'(k));
      match[k] = (LEN_W'(k) < cfg_i.len) && (win_sh[sel] == cfg_i.key[k]);
    end
  end

  always_comb begin
    res_d.score  = SCORE_W'($countones(match));
    res_d.start  = INDEX_W'(cnt_inc - CNT_W'(cfg_i.len));
    res_d.win_ok = !sat && (cnt_inc >= CNT_W'(cfg_i.len));
    res_d.ovf    = sat;
    res_d.last   = last_byte_i;

    win_d = win_q;
    cnt_d = cnt_q;
    if (last_byte_i) begin
      win_d = '0;
      cnt_d = '0;
    end else if (!sat) begin
      win_d = win_sh;
      cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        win_q <= win_d;
        cnt_q <= cnt_d;
      end
      if (advance_i) begin
        res_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[design/bhwm_tracker.sv]
// ---------------------------------------------------------------------------
// bhwm_tracker
// keeps the best window of the current text and holds the result register
// ---------------------------------------------------------------------------
`include "best_hamming_window_match_defines.svh"

module bhwm_tracker import bhwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  win_res_t           res_i,
  output logic               advance_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [INDEX_W-1:0] best_index_o,
  output logic [SCORE_W-1:0] best_score_o,
  output logic               overflow_o
);

  logic [SCORE_W-1:0] top_score_q, top_score_d;
  logic [INDEX_W-1:0] top_index_q, top_index_d;
  logic               ovf_q, ovf_d;
  logic               out_valid_q;
  logic [INDEX_W-1:0] out_index_q;
  logic [SCORE_W-1:0] out_score_q;
  logic               out_ovf_q;
  logic               fire;
  logic               better;

  // only a finished text stuck behind an untaken result holds the pipe
  assign advance_o = !(res_valid_i && res_i.last && out_valid_q && !out_ready_i);
  assign fire      = res_valid_i & advance_o;

  always_comb begin
    better      = res_i.win_ok && (res_i.score > top_score_q);
    top_score_d = better ? res_i.score : top_score_q;
    top_index_d = better ? res_i.start : top_index_q;
    ovf_d       = ovf_q | res_i.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_score_q <= '0;
      top_index_q <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        if (res_i.last) begin
          top_score_q <= '0;
          top_index_q <= '0;
          ovf_q       <= 1'b0;
        end else begin
          top_score_q <= top_score_d;
          top_index_q <= top_index_d;
          ovf_q       <= ovf_d;
        end
      end
      if (fire && res_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_i.last) begin
      out_index_q <= top_index_d;
      out_score_q <= top_score_d;
      out_ovf_q   <= ovf_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_index_o = out_index_q;
  assign best_score_o = out_score_q;
  assign overflow_o   = out_ovf_q;

  `BHWM_ASSERT_ALWAYS(a_score_bound, top_score_q <= SCORE_W'(KEY_MAX), "best score above key size")
  `BHWM_ASSERT_NEXT(a_score_grows, fire && !res_i.last, top_score_q >= $past(top_score_q), "best score fell mid-text")
  `BHWM_ASSERT_NEXT(a_clear_on_last, fire && res_i.last, top_score_q == '0 && top_index_q == '0 && !ovf_q, "text state not cleared")
  `BHWM_ASSERT_IMPL(a_zero_index, out_valid_q && out_score_q == '0, out_index_q == '0, "index set without a match")

endmodule

[design/best_hamming_window_match.sv]
// ---------------------------------------------------------------------------
// best_hamming_window_match
// streaming search for the best key match over sliding text windows
// ---------------------------------------------------------------------------
// text bytes enter on the in_* channel, one transfer per byte, last_byte_i
// marking the final byte of a text. every byte that completes a window of
// key length is scored by counting equal byte positions against the key;
// the first window with the strictly highest score is kept.
// one result transfer leaves on the out_* channel per text: best_index_o,
// best_score_o and overflow_o (text longer than TEXT_MAX bytes).
// throughput: one byte per cycle, back to back, while in_ready_o is high;
// the 16-lane compare and popcount in the window stage are combinational.
// after the final byte's transfer the result passes the score register,
// then the result register, before it is valid on the out_* channel.
// a stalled receiver does not stop the text stream: in_ready_o drops only
// while a second final byte waits behind a result not yet taken.
// reset clears the window, byte count and best-so-far state, sets the key
// to zero and the key length to one. the user writes the apb key registers
// between texts, unchecked by the block; every later window uses them.
// ---------------------------------------------------------------------------
module best_hamming_window_match import bhwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // text stream
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [BYTE_W-1:0]  text_byte_i,
  input  logic               last_byte_i,
  // result stream
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [INDEX_W-1:0] best_index_o,
  output logic [SCORE_W-1:0] best_score_o,
  output logic               overflow_o
);

  key_cfg_t key_cfg;
  win_res_t win_res;
  logic     win_res_valid;
  logic     advance;

  // key bytes, length and its clipped form
  bhwm_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (key_cfg)
  );

  // shift line and window scoring, registered at the transfer edge
  bhwm_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (key_cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_byte_i (text_byte_i),
    .last_byte_i (last_byte_i),
    .advance_i   (advance),
    .res_valid_o (win_res_valid),
    .res_o       (win_res)
  );

  // best-so-far compare and result register
  bhwm_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (win_res_valid),
    .res_i        (win_res),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .best_index_o (best_index_o),
    .best_score_o (best_score_o),
    .overflow_o   (overflow_o)
  );

endmodule
